[rtl/imarsd_pkg.sv]
// ============================================================================
// IMA ADPCM resampling decoder - shared package
// Widths, codes, request and result records, and the ADPCM step tables.
// ============================================================================
package imarsd_pkg;

    localparam int SIZE_BITS = 20;
    localparam int FRAC_W    = 12;
    localparam int PHASE_W   = SIZE_BITS + FRAC_W + 1;
    localparam int INC_W     = 16;
    localparam int NIB_W     = 20;
    localparam int ADDR_W    = 19;
    localparam int CFG_W     = 20;
    localparam int SAMP_W    = 16;
    localparam int IDX_W     = 7;
    localparam int STEP_W    = 15;
    localparam int BYTE_W    = 8;
    localparam int NIB_USE   = (SIZE_BITS < NIB_W) ? SIZE_BITS : NIB_W;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [IDX_W-1:0]         IDX_MAX  = 7'd88;
    localparam logic signed [SAMP_W-1:0] PCM_MAX  = 16'sh7FFF;
    localparam logic signed [SAMP_W-1:0] PCM_MIN  = 16'sh8000;
    localparam logic signed [SAMP_W-1:0] OUT_MIN  = 16'sh8001;
    localparam logic [INC_W-1:0]         INC_RESET = 16'h1000;
    localparam logic [NIB_W-1:0]         NIB_RESET = 20'h00001;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_PHASE_INC      = 1'b0,
        CFG_SAMPLE_NIBBLES = 1'b1
    } t_cfg_idx;

    // Classification of an incoming request.
    typedef enum logic {
        K_STEP  = 1'b0,
        K_BEGIN = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  rom_byte;
    } t_req;

    typedef struct packed {
        logic [INC_W-1:0] phase_inc;
        logic [NIB_W-1:0] sample_nibbles;
    } t_cfg;

    typedef struct packed {
        logic                     sample_valid;
        logic signed [SAMP_W-1:0] sample_out;
        logic                     last;
        logic                     byte_needed;
        logic [ADDR_W-1:0]        byte_address;
    } t_result;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
        15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
        15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
        15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
        15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
        15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
        15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
        15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Step index adjustment for the three magnitude bits of a nibble.
    function automatic logic signed [4:0] idx_adj(input logic [2:0] mag);
        logic signed [4:0] adj;
        case (mag)
            3'd4:    adj = 5'sd2;
            3'd5:    adj = 5'sd4;
            3'd6:    adj = 5'sd6;
            3'd7:    adj = 5'sd8;
            default: adj = -5'sd1;
        endcase
        return adj;
    endfunction

endpackage

[rtl/imarsd_front.sv]
// ============================================================================
// IMA ADPCM resampling decoder - front end
// Accepts requests, tags them as begin or step, and queues them for the back end.
// ============================================================================
module imarsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_begin_req,
    input  logic [7:0]          i_rom_byte,
    output logic                o_q_valid,
    output imarsd_pkg::t_req    o_q_req,
    input  logic                i_q_pop
);
    import imarsd_pkg::*;

    t_req               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               push;
    logic               pop;
    t_req               req_in;

    assign o_in_stall = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_req    = r_mem[r_rd];

    always_comb begin
        req_in.kind     = i_begin_req ? K_BEGIN : K_STEP;
        req_in.rom_byte = i_rom_byte;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= req_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // The fill count tracks the distance between the two pointers.
    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != Q_CNT_W'(Q_DEPTH)) |-> (r_cnt[Q_PTR_W-1:0] == Q_PTR_W'(r_wr - r_rd)))
        else $error("queue count out of step with pointers");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == Q_CNT_W'(Q_DEPTH)) |=> (r_cnt != '0))
        else $error("queue emptied from full in one cycle");

endmodule

[rtl/imarsd_back.sv]
// ============================================================================
// IMA ADPCM resampling decoder - back end
// Three-step sequencer: nibble decode and phase advance, interpolation
// multiply, then rounding, clamp and result register.
// ============================================================================
module imarsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imarsd_pkg::t_cfg    i_cfg,
    input  logic                i_q_valid,
    input  imarsd_pkg::t_req    i_q_req,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output imarsd_pkg::t_result o_result
);
    import imarsd_pkg::*;

    typedef enum logic [2:0] {
        S_DEC = 3'b001,
        S_MUL = 3'b010,
        S_OUT = 3'b100
    } t_state;

    t_state                   r_state;
    logic [PHASE_W-1:0]       r_phase;
    logic signed [SAMP_W-1:0] r_prev;
    logic signed [SAMP_W-1:0] r_cur;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_hold;
    logic                     r_first;
    logic                     r_fin;

    // Per-request pipeline registers.
    logic                     r_act;
    logic                     r_smp_vld;
    logic                     r_bit_chg;
    logic [FRAC_W-1:0]        r_frac;
    logic                     r_last;
    logic                     r_need;
    logic [ADDR_W-1:0]        r_addr;
    logic signed [29:0]       r_prod;

    logic                     r_out_vld;
    t_result                  r_out;

    // Effective state after an optional begin.
    logic                     is_begin;
    logic [PHASE_W-1:0]       e_phase;
    logic signed [SAMP_W-1:0] e_cur;
    logic [IDX_W-1:0]         e_idx;
    logic                     e_hold;
    logic                     e_first;
    logic                     e_fin;
    logic                     act;

    logic [3:0]               nib;
    logic [IDX_W-1:0]         si;
    logic [STEP_W-1:0]        step;
    logic [16:0]              dq;
    logic signed [17:0]       v18;
    logic signed [SAMP_W-1:0] v_sat;
    logic signed [8:0]        ni;
    logic [IDX_W-1:0]         ni_sat;
    logic [PHASE_W-1:0]       p1;
    logic [PHASE_W-1:0]       end_phase;
    logic                     fin_n;
    logic                     hold_n;

    logic signed [16:0]       dv;
    logic signed [17:0]       quo;
    logic signed [18:0]       data19;
    logic signed [SAMP_W-1:0] data;
    logic                     out_free;
    logic                     pop;

    assign pop     = (r_state == S_DEC) && i_q_valid;
    assign o_q_pop = pop;

    always_comb begin
        is_begin = (i_q_req.kind == K_BEGIN);
        e_phase  = is_begin ? '0 : r_phase;
        e_cur    = is_begin ? '0 : r_cur;
        e_idx    = is_begin ? '0 : r_idx;
        e_hold   = is_begin ? 1'b0 : r_hold;
        e_first  = is_begin ? 1'b1 : r_first;
        e_fin    = is_begin ? 1'b0 : r_fin;
        act      = !e_fin && (i_cfg.phase_inc != '0);

        // Even nibble index takes the high half of the byte.
        nib  = e_phase[FRAC_W] ? i_q_req.rom_byte[3:0] : i_q_req.rom_byte[7:4];
        si   = (e_idx > IDX_MAX) ? IDX_MAX : e_idx;
        step = STEP_TABLE[si];
        dq   = 17'(step >> 3);
        if (nib[2]) begin
            dq = dq + 17'(step);
        end
        if (nib[1]) begin
            dq = dq + 17'(step >> 1);
        end
        if (nib[0]) begin
            dq = dq + 17'(step >> 2);
        end
        v18 = nib[3] ? (18'(e_cur) - $signed({1'b0, dq}))
                     : (18'(e_cur) + $signed({1'b0, dq}));
        if (v18 > 18'(PCM_MAX)) begin
            v_sat = PCM_MAX;
        end else if (v18 < 18'(PCM_MIN)) begin
            v_sat = PCM_MIN;
        end else begin
            v_sat = SAMP_W'(v18);
        end
        ni = $signed({2'b00, si}) + 9'(idx_adj(nib[2:0]));
        if (ni < 0) begin
            ni_sat = '0;
        end else if (ni > $signed({2'b00, IDX_MAX})) begin
            ni_sat = IDX_MAX;
        end else begin
            ni_sat = IDX_W'(ni);
        end

        p1        = e_phase + PHASE_W'(i_cfg.phase_inc);
        end_phase = PHASE_W'(i_cfg.sample_nibbles[NIB_USE-1:0]) << FRAC_W;
        fin_n     = (p1 >= end_phase);
        hold_n    = (e_phase[FRAC_W] == p1[FRAC_W]);
    end

    // Interpolation: prev + floor(diff * frac / 4096), clamped symmetric.
    always_comb begin
        dv     = 17'(r_cur) - 17'(r_prev);
        quo    = 18'(r_prod >>> FRAC_W);
        data19 = 19'(r_prev) + 19'(quo);
        if (data19 > 19'(PCM_MAX)) begin
            data = PCM_MAX;
        end else if (data19 < 19'(OUT_MIN)) begin
            data = OUT_MIN;
        end else begin
            data = SAMP_W'(data19);
        end
    end

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_DEC;
            r_phase   <= '0;
            r_prev    <= '0;
            r_cur     <= '0;
            r_idx     <= '0;
            r_hold    <= 1'b0;
            r_first   <= 1'b1;
            r_fin     <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_DEC: begin
                    if (pop) begin
                        r_state <= S_MUL;
                        if (is_begin) begin
                            r_prev <= '0;
                        end
                        if (act) begin
                            r_phase <= p1;
                            r_cur   <= e_hold ? e_cur : v_sat;
                            r_idx   <= e_hold ? e_idx : ni_sat;
                            r_hold  <= hold_n;
                            r_first <= 1'b0;
                            r_fin   <= fin_n;
                        end else begin
                            r_phase <= e_phase;
                            r_cur   <= e_cur;
                            r_idx   <= e_idx;
                            r_hold  <= e_hold;
                            r_first <= e_first;
                            r_fin   <= e_fin;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_DEC;
                        if (r_act && r_bit_chg) begin
                            r_prev <= r_cur;
                        end
                    end
                end
                default: begin
                    r_state <= S_DEC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_act     <= act;
            r_smp_vld <= act && !e_first;
            r_bit_chg <= !hold_n;
            r_frac    <= e_phase[FRAC_W-1:0];
            r_last    <= act && fin_n;
            r_need    <= act && !fin_n && !hold_n;
            r_addr    <= (act && !fin_n) ? ADDR_W'(p1 >> (FRAC_W + 1)) : '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= dv * $signed({1'b0, r_frac});
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out.sample_valid <= r_smp_vld;
            r_out.sample_out   <= r_smp_vld ? data : '0;
            r_out.last         <= r_last;
            r_out.byte_needed  <= r_need;
            r_out.byte_address <= r_addr;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_MAX)
        else $error("step index beyond table");

    a_last_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.last) |-> (!r_out.byte_needed && r_out.byte_address == '0))
        else $error("byte requested after end of sample");

    a_out_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.sample_out != PCM_MIN))
        else $error("output sample escaped clamp");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !pop)
        else $error("second request taken while one in flight");

endmodule

[rtl/ima_adpcm_resampling_decoder_core.sv]
// ============================================================================
// IMA ADPCM resampling decoder - top level
// Decodes 4-bit IMA ADPCM and resamples it by linear interpolation.
// ============================================================================
// Usage:
//   Each input request (i_begin_req, i_rom_byte) is one phase step of the
//   resampler and yields exactly one result request. A request with
//   i_begin_req set restarts the sample; its byte is byte 0 of the sample.
//   Later requests carry the byte at the o_byte_address given by the result
//   of the previous request, when o_byte_needed was set.
//   Both channels use valid/stall: a request moves on an edge with valid high
//   and stall low. The input side has a four-entry queue, so requests are
//   taken while earlier ones are still being decoded or wait at the output.
//   The back end takes each request through decode, multiply, then round and
//   clamp into the result register, and pops no new request until that result
//   is registered; a stall at the output holds it in the round-and-clamp step.
//   When the receiver stalls, the result holds, the back end waits, and the
//   queue fills before o_in_stall rises.
//   Reset clears the queue and the decoder; the block then idles (all-zero
//   results) until a begin request. Configuration must be written through
//   i_cfg_we/i_cfg_index/i_cfg_data only while the block is idle; unchecked.
// ============================================================================
module ima_adpcm_resampling_decoder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [19:0]  i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic         i_begin_req,
    input  logic [7:0]   i_rom_byte,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_sample_valid,
    output logic [15:0]  o_sample_out,
    output logic         o_last,
    output logic         o_byte_needed,
    output logic [18:0]  o_byte_address
);
    import imarsd_pkg::*;

    logic [INC_W-1:0] r_phase_inc;
    logic [NIB_W-1:0] r_sample_nibbles;
    t_cfg             cfg;
    logic             q_valid;
    t_req             q_req;
    logic             q_pop;
    t_result          result;

    // Configuration registers; writes are plain and unacknowledged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc      <= INC_RESET;
            r_sample_nibbles <= NIB_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PHASE_INC:      r_phase_inc      <= i_cfg_data[INC_W-1:0];
                CFG_SAMPLE_NIBBLES: r_sample_nibbles <= i_cfg_data[NIB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.phase_inc      = r_phase_inc;
    assign cfg.sample_nibbles = r_sample_nibbles;

    // Front end: takes requests and buffers them for the decoder.
    imarsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_begin_req (i_begin_req),
        .i_rom_byte  (i_rom_byte),
        .o_q_valid   (q_valid),
        .o_q_req     (q_req),
        .i_q_pop     (q_pop)
    );

    // Back end: decoder state, interpolation and the result register.
    imarsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_sample_valid = result.sample_valid;
    assign o_sample_out   = result.sample_out;
    assign o_last         = result.last;
    assign o_byte_needed  = result.byte_needed;
    assign o_byte_address = result.byte_address;

endmodule
